@@ src/fsa_pkg.sv @@
// Shared types and constants for the fixed slot allocator.
// Used by every module under src; no dependencies of its own.
package fsa_pkg;

	localparam int AddrW      = 10;
	localparam int StackDepth = 1024;
	localparam int PtrW       = $clog2(StackDepth);
	localparam int CntW       = PtrW + 1;

	localparam int SlotsPerChunkDef = 256;
	localparam int MaxChunksDef     = 4;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	// Stack memory access for one request
	typedef struct packed {
		logic            wr_en;
		logic [PtrW-1:0] wr_ptr;
		logic [AddrW-1:0] wr_data;
		logic            rd_en;
		logic [PtrW-1:0] rd_ptr;
	} mem_req_t;

	// Result handoff to the output stage
	typedef struct packed {
		logic             load;
		logic             pend;
		logic [AddrW-1:0] slot;
		logic             ok;
	} res_t;

endpackage

@@ src/fsa_stack_mem.sv @@
// Free stack storage: one write port and one registered read port.
// Depends on fsa_pkg for widths and the request struct.
module fsa_stack_mem (
	input  logic                      clk,
	input  fsa_pkg::mem_req_t         req,
	output logic [fsa_pkg::AddrW-1:0] rd_data
);

	logic [fsa_pkg::AddrW-1:0] mem [fsa_pkg::StackDepth];
	logic [fsa_pkg::AddrW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_ptr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_ptr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/fsa_ctrl.sv @@
// Allocator bookkeeping: stack count, open chunks, bump offset, decisions.
// Depends on fsa_pkg; drives the stack memory and the output stage.
module fsa_ctrl #(
	parameter int SLOTS_PER_CHUNK = fsa_pkg::SlotsPerChunkDef,
	parameter int MAX_CHUNKS      = fsa_pkg::MaxChunksDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic                      op,
	input  logic [fsa_pkg::AddrW-1:0] address,
	output fsa_pkg::mem_req_t         mem_req,
	output fsa_pkg::res_t             res
);

	localparam int ChW  = $clog2(MAX_CHUNKS + 1);
	localparam int OfsW = $clog2(SLOTS_PER_CHUNK + 1);
	localparam int LimW = $clog2(MAX_CHUNKS * SLOTS_PER_CHUNK + 1);
	localparam int CmpW = (LimW > fsa_pkg::AddrW) ? LimW : fsa_pkg::AddrW;
	localparam logic [fsa_pkg::AddrW-1:0] SpcMod =
		fsa_pkg::AddrW'(SLOTS_PER_CHUNK % (2 ** fsa_pkg::AddrW));

	logic [fsa_pkg::CntW-1:0]  count_q, count_d, count_dec;
	logic [ChW-1:0]            chunks_q, chunks_d, eff_chunks;
	logic [OfsW-1:0]           bump_q, bump_d, eff_bump;
	logic [fsa_pkg::AddrW-1:0] base_q, base_d;
	logic [LimW-1:0]           limit_q, limit_d, eff_limit;
	logic                      in_range, stack_full;

	assign count_dec  = count_q - 1'b1;
	assign eff_chunks = (chunks_q == '0) ? ChW'(1) : chunks_q;
	assign eff_bump   = (chunks_q == '0) ? OfsW'(1) : bump_q;
	assign eff_limit  = (chunks_q == '0) ? LimW'(SLOTS_PER_CHUNK) : limit_q;
	assign in_range   = CmpW'(address) < CmpW'(limit_q);
	assign stack_full = count_q == fsa_pkg::CntW'(fsa_pkg::StackDepth);

	always_comb begin
		count_d  = count_q;
		chunks_d = chunks_q;
		bump_d   = bump_q;
		base_d   = base_q;
		limit_d  = limit_q;
		mem_req  = '0;
		res      = '0;
		if (accept) begin
			if (op == fsa_pkg::OP_FREE) begin
				res.load = 1'b1;
				if (in_range && !stack_full) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_ptr  = count_q[fsa_pkg::PtrW-1:0];
					mem_req.wr_data = address;
					count_d         = count_q + 1'b1;
					res.ok          = 1'b1;
				end
			end else begin
				// open chunk 0 lazily on the first allocation
				chunks_d = eff_chunks;
				bump_d   = eff_bump;
				limit_d  = eff_limit;
				if (count_q != '0) begin
					mem_req.rd_en  = 1'b1;
					mem_req.rd_ptr = count_dec[fsa_pkg::PtrW-1:0];
					count_d        = count_dec;
					res.pend       = 1'b1;
				end else if (eff_bump < OfsW'(SLOTS_PER_CHUNK)) begin
					res.load = 1'b1;
					res.ok   = 1'b1;
					res.slot = base_q + fsa_pkg::AddrW'(eff_bump);
					bump_d   = eff_bump + 1'b1;
				end else if (eff_chunks >= ChW'(MAX_CHUNKS)) begin
					res.load = 1'b1;
				end else begin
					res.load = 1'b1;
					res.ok   = 1'b1;
					res.slot = base_q + SpcMod + 1'b1;
					base_d   = base_q + SpcMod;
					chunks_d = eff_chunks + 1'b1;
					bump_d   = OfsW'(2);
					limit_d  = eff_limit + LimW'(SLOTS_PER_CHUNK);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			chunks_q <= '0;
			bump_q   <= '0;
			base_q   <= '0;
			limit_q  <= '0;
		end else begin
			count_q  <= count_d;
			chunks_q <= chunks_d;
			bump_q   <= bump_d;
			base_q   <= base_d;
			limit_q  <= limit_d;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fsa_pkg::CntW'(fsa_pkg::StackDepth))
		else $error("free stack count overran its depth");

	a_chunks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		chunks_q <= ChW'(MAX_CHUNKS))
		else $error("more chunks open than available");

	a_no_push_unopened: assert property (@(posedge clk) disable iff (!arst_n)
		chunks_q == '0 |-> count_q == '0)
		else $error("stack holds entries before any chunk was opened");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.rd_en |-> count_q != '0 && !mem_req.wr_en)
		else $error("pop issued on an empty stack or with a push");

endmodule

@@ src/fsa_out.sv @@
// Result register: takes immediate results, or popped stack data once the registered stack read returns.
// Depends on fsa_pkg for the result struct; also produces request ready.
module fsa_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  fsa_pkg::res_t             res,
	input  logic [fsa_pkg::AddrW-1:0] mem_rd_data,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic [fsa_pkg::AddrW-1:0] out_slot,
	output logic                      out_ok,
	output logic                      in_ready
);

	logic                      valid_q;
	logic                      pend_q;
	logic [fsa_pkg::AddrW-1:0] slot_q;
	logic                      ok_q;

	// hold off new requests while a pop is in flight or the result is stuck
	assign in_ready = !pend_q && (!valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= res.pend;
			if (pend_q || res.load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			slot_q <= mem_rd_data;
			ok_q   <= 1'b1;
		end else if (res.load) begin
			slot_q <= res.slot;
			ok_q   <= res.ok;
		end
	end

	assign out_valid = valid_q;
	assign out_slot  = slot_q;
	assign out_ok    = ok_q;

	a_pend_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !valid_q)
		else $error("popped data arrives while a result is still held");

	a_pend_single: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |=> !pend_q)
		else $error("second pop issued while one was in flight");

	a_load_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.load && res.pend) && !(pend_q && (res.load || res.pend)))
		else $error("result loaded from two sources at once");

endmodule

@@ src/fixed_slot_allocator.sv @@
// Fixed slot allocator top level: control, free stack memory, result register.
// Depends on fsa_pkg, fsa_ctrl, fsa_stack_mem and fsa_out.
//
//   channel | handshake              | beat fields
//   --------+------------------------+------------------------
//   request | req_valid / req_ready  | op, address
//   result  | rsp_valid / rsp_ready  | slot, ok
//
// A free, a bump allocation or a failed allocation loads the result
// register directly; an allocation served from the free stack first
// passes through the registered read port of the stack memory. The result
// register lets a new request in while the result beat is being taken. Reset
// clears counts and chunk state at once; stack entries are never cleared. A
// stalled result beat blocks further requests.
module fixed_slot_allocator #(
	parameter int SLOTS_PER_CHUNK = fsa_pkg::SlotsPerChunkDef,
	parameter int MAX_CHUNKS      = fsa_pkg::MaxChunksDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic                      op,
	input  logic [fsa_pkg::AddrW-1:0] address,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic [fsa_pkg::AddrW-1:0] slot,
	output logic                      ok
);

	fsa_pkg::mem_req_t         mem_req;
	fsa_pkg::res_t             res;
	logic [fsa_pkg::AddrW-1:0] mem_rd_data;
	logic                      accept;

	assign accept = req_valid && req_ready;

	fsa_ctrl #(
		.SLOTS_PER_CHUNK (SLOTS_PER_CHUNK),
		.MAX_CHUNKS      (MAX_CHUNKS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.op      (op),
		.address (address),
		.mem_req (mem_req),
		.res     (res)
	);

	fsa_stack_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	fsa_out u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.res         (res),
		.mem_rd_data (mem_rd_data),
		.out_ready   (rsp_ready),
		.out_valid   (rsp_valid),
		.out_slot    (slot),
		.out_ok      (ok),
		.in_ready    (req_ready)
	);

endmodule
